>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication, checked on every rising edge outside reset.
`define EMMS_ASSERT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("emms assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define EMMS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("emms assertion failed");

`endif

>>> sv/emms_pkg.sv
// Shared widths and register indexes for the multiplet spread block.
`timescale 1ns / 1ps

package emms_pkg;

    localparam int TIME_W    = 48;
    localparam int MIN_W     = 56;
    localparam int WS_W      = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_BOUND = 1'd1;

    localparam logic [WS_W-1:0]  WINDOW_SIZE_RST = 5'd2;
    localparam logic [MIN_W-1:0] START_BOUND_RST = {MIN_W{1'b1}};

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [MIN_W-1:0]  spread_t;

endpackage

>>> sv/emms_window_ram.sv
// Timestamp ring memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module emms_window_ram
    import emms_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  time_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output time_t         rd_data_a,
    output time_t         rd_data_b
);

    time_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

>>> sv/event_multiplet_min_spread.sv
// Top level: windowed weighted-spread minimum over a timestamp stream.
//
//  channel   direction  handshake              payload
//  evt       in         evt_valid / evt_stall  event_time, last_of_set
//  res       out        res_valid / res_stall  min_spread, window_seen, set_done
//  cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item that completes a window of m >= 2 entries runs a pass from acceptance
// to result: one ring read of a timestamp pair per cycle, then a drain of the
// read, difference, product and accumulate stages, then a load of the output
// register once it is free. Any other item goes straight to that load. Items are
// worked one at a time; evt_stall stays high until the result moves into the
// output register, which holds it while res_stall is high.
// Reset is asynchronous; the ring needs no clearing since the fill count gates
// every read.
`timescale 1ns / 1ps

module event_multiplet_min_spread
    import emms_pkg::*;
#(
    parameter int MAX_WINDOW = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 evt_valid,
    output logic                 evt_stall,
    input  logic [TIME_W-1:0]    event_time,
    input  logic                 last_of_set,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [MIN_W-1:0]     min_spread,
    output logic                 window_seen,
    output logic                 set_done,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MIN_W-1:0]     cfg_data
);

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int MW    = $clog2(MAX_WINDOW + 1);
    localparam int CW    = (MW > WS_W) ? MW : WS_W;
    localparam int DW    = TIME_W + 1;
    localparam int PW    = DW + AW + 1;
    localparam int ACC_W = DW + 1 + 2 * AW;
    localparam int SAT_W = ((ACC_W > MIN_W + 1) ? ACC_W : MIN_W + 1) + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]    state_reg;
    logic [WS_W-1:0] window_size_reg;
    spread_t       start_bound_reg;

    logic [AW-1:0] wp_reg;
    logic [AW-1:0] newest_reg;
    logic [MW-1:0] fill_reg;
    logic [MW-1:0] m_reg;
    logic [MW-1:0] npairs_reg;
    logic [MW-1:0] k_reg;
    logic          win_reg;
    logic          last_reg;
    logic          any_reg;
    spread_t       run_min_reg;

    logic          rd_v_reg;
    logic [AW-1:0] w1_reg;
    logic signed [DW-1:0] diff_reg;
    logic [AW-1:0] w2_reg;
    logic          v2_reg;
    logic signed [PW-1:0] prod_reg;
    logic          v3_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic          res_valid_reg;
    spread_t       min_spread_reg;
    logic          window_seen_reg;
    logic          set_done_reg;

    logic          evt_acc;
    logic [CW-1:0] ws_ext;
    logic [MW-1:0] m_eff;
    logic [MW-1:0] fill_inc;
    logic          win_now;
    logic [MW-1:0] npairs_eff;
    logic          rd_en;
    logic [AW-1:0] addr_hi;
    logic [AW-1:0] addr_lo;
    logic [AW-1:0] weight;
    time_t         q_hi;
    time_t         q_lo;
    logic signed [SAT_W-1:0] acc_wide;
    spread_t       spread;
    spread_t       base_min;
    spread_t       cur_min;
    logic          out_free;
    logic          finish;

    function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] b, input logic [AW-1:0] o);
        logic [AW:0] bx;
        logic [AW:0] ox;
        bx = {1'b0, b};
        ox = {1'b0, o};
        if (bx >= ox)
        begin
            ring_sub = AW'(bx - ox);
        end
        else
        begin
            ring_sub = AW'(bx + (AW + 1)'(MAX_WINDOW) - ox);
        end
    endfunction

    assign cfg_ready = 1'b1;
    assign evt_stall = (state_reg != S_IDLE);
    assign evt_acc   = evt_valid && (state_reg == S_IDLE);

    // Effective window size: zero acts as one, clamp to the ring depth.
    assign ws_ext = CW'(window_size_reg);
    always_comb
    begin
        if (ws_ext == '0)
        begin
            m_eff = MW'(1);
        end
        else if (ws_ext > CW'(MAX_WINDOW))
        begin
            m_eff = MW'(MAX_WINDOW);
        end
        else
        begin
            m_eff = MW'(ws_ext);
        end
    end

    assign fill_inc   = (fill_reg == MW'(MAX_WINDOW)) ? fill_reg : fill_reg + MW'(1);
    assign win_now    = (fill_inc >= m_eff);
    assign npairs_eff = m_eff >> 1;

    assign rd_en   = (state_reg == S_ISSUE);
    assign addr_hi = ring_sub(newest_reg, k_reg[AW-1:0]);
    assign addr_lo = ring_sub(newest_reg, AW'(m_reg - MW'(1) - k_reg));
    assign weight  = AW'(m_reg - MW'(1) - (k_reg << 1));

    emms_window_ram #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_ram (
        .clk       (clk),
        .wr_en     (evt_acc),
        .wr_addr   (wp_reg),
        .wr_data   (event_time),
        .rd_en     (rd_en),
        .rd_addr_a (addr_hi),
        .rd_addr_b (addr_lo),
        .rd_data_a (q_hi),
        .rd_data_b (q_lo)
    );

    // Saturate the signed sum into the result range.
    assign acc_wide = {{(SAT_W - ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
    always_comb
    begin
        if (acc_wide[SAT_W-1])
        begin
            spread = '0;
        end
        else if (|acc_wide[SAT_W-2:MIN_W])
        begin
            spread = '1;
        end
        else
        begin
            spread = acc_wide[MIN_W-1:0];
        end
    end

    assign base_min = any_reg ? run_min_reg : start_bound_reg;
    assign cur_min  = (win_reg && (spread < base_min)) ? spread : base_min;
    assign out_free = !res_valid_reg || !res_stall;
    assign finish   = (state_reg == S_DONE) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RST;
            start_bound_reg <= START_BOUND_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE: window_size_reg <= cfg_data[WS_W-1:0];
                REG_START_BOUND: start_bound_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            fill_reg  <= '0;
            any_reg   <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (evt_acc)
                    begin
                        wp_reg   <= (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : wp_reg + AW'(1);
                        fill_reg <= fill_inc;
                        k_reg    <= '0;
                        if (win_now && (npairs_eff != '0))
                        begin
                            state_reg <= S_ISSUE;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_ISSUE:
                begin
                    k_reg <= k_reg + MW'(1);
                    if (k_reg == npairs_reg - MW'(1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!rd_v_reg && !v2_reg && !v3_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                        if (last_reg)
                        begin
                            fill_reg <= '0;
                            any_reg  <= 1'b0;
                        end
                        else
                        begin
                            any_reg <= any_reg || win_reg;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Per-item context; held for the whole pass.
    always_ff @(posedge clk)
    begin
        if (evt_acc)
        begin
            newest_reg <= wp_reg;
            m_reg      <= m_eff;
            npairs_reg <= npairs_eff;
            win_reg    <= win_now;
            last_reg   <= last_of_set;
        end
        if (finish && win_reg && !last_reg)
        begin
            run_min_reg <= cur_min;
        end
    end

    // Multiply-add pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end
        else
        begin
            rd_v_reg <= rd_en;
            v2_reg   <= rd_v_reg;
            v3_reg   <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            w1_reg <= weight;
        end
        diff_reg <= $signed({1'b0, q_hi}) - $signed({1'b0, q_lo});
        w2_reg   <= w1_reg;
        prod_reg <= diff_reg * $signed({1'b0, w2_reg});
        if (evt_acc)
        begin
            acc_reg <= '0;
        end
        else if (v3_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W - PW){prod_reg[PW-1]}}, prod_reg};
        end
    end

    // Output register: load on finish, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            min_spread_reg  <= cur_min;
            window_seen_reg <= any_reg || win_reg;
            set_done_reg    <= last_reg;
        end
    end

    assign res_valid   = res_valid_reg;
    assign min_spread  = min_spread_reg;
    assign window_seen = window_seen_reg;
    assign set_done    = set_done_reg;

endmodule

>>> sv/emms_checker.sv
// Port-level checker for the multiplet spread block, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module emms_checker
    import emms_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             evt_valid,
    input logic             evt_stall,
    input logic             res_valid,
    input logic             res_stall,
    input logic [MIN_W-1:0] min_spread,
    input logic             window_seen,
    input logic             set_done
);

    logic       prev_open_reg;
    spread_t    prev_min_reg;

    // Track the last delivered minimum while a set with a window stays open.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_open_reg <= 1'b0;
            prev_min_reg  <= '0;
        end
        else if (res_valid && !res_stall)
        begin
            prev_open_reg <= window_seen && !set_done;
            prev_min_reg  <= min_spread;
        end
    end

    `EMMS_ASSERT_NEXT(busy_after_accept, clk, rst_n, evt_valid && !evt_stall, evt_stall)
    `EMMS_ASSERT_NEXT(result_held, clk, rst_n, res_valid && res_stall, res_valid && $stable(min_spread))
    `EMMS_ASSERT_NEXT(flags_held, clk, rst_n, res_valid && res_stall, $stable(window_seen) && $stable(set_done))
    `EMMS_ASSERT(min_never_rises, clk, rst_n, res_valid && prev_open_reg, window_seen && (min_spread <= prev_min_reg))

endmodule

bind event_multiplet_min_spread emms_checker u_emms_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .evt_valid   (evt_valid),
    .evt_stall   (evt_stall),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .min_spread  (min_spread),
    .window_seen (window_seen),
    .set_done    (set_done)
);
